/* design/stack_machine_executor_top_macros.svh */
`ifndef STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH

// Both macros expect signals named clock and reset in the enclosing scope.
`define SME_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/sme_pkg.sv */
package sme_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int DATA_W      = 32;
   localparam int DEPTH_W     = 6;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int ITER_W      = $clog2(DATA_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] ACT_PUSH = 4'd1;
   localparam logic [3:0] ACT_POP  = 4'd2;
   localparam logic [3:0] ACT_ADD  = 4'd3;
   localparam logic [3:0] ACT_SUB  = 4'd4;
   localparam logic [3:0] ACT_MUL  = 4'd5;
   localparam logic [3:0] ACT_DIV  = 4'd6;
   localparam logic [3:0] ACT_NOP  = 4'd7;
   localparam logic [3:0] ACT_DUMP = 4'd8;
   localparam logic [3:0] ACT_NOP2 = 4'd9;
   localparam logic [3:0] ACT_HALT = 4'd10;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_HALTED  = 3'd1,
      ST_SYNTAX  = 3'd2,
      ST_UNDER   = 3'd3,
      ST_OVER    = 3'd4,
      ST_DIVZERO = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      KIND_PUSH,
      KIND_POP,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_NOP,
      KIND_DUMP,
      KIND_HALT,
      KIND_SYNTAX,
      KIND_STOPPED
   } kind_type;

   typedef struct packed {
      logic [3:0]         action;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] value;
      logic               is_element;
      logic               last;
      logic [5:0]         depth;
   } rsp_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] operand;
   } cmd_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* design/sme_ram.sv */
module sme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sme_div.sv */
module sme_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sme_pkg::div_req_type div_req,
   output sme_pkg::div_rsp_type div_rsp
);
   import sme_pkg::*;

   logic              busy_ff, busy_in;
   logic              neg_ff, neg_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   shifted;
   logic              fits;

   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         iter_in = '0;
         rem_in  = '0;
         neg_in  = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
         quo_in  = div_req.dividend[DATA_W-1] ? -div_req.dividend : div_req.dividend;
         dvs_in  = div_req.divisor[DATA_W-1] ? -div_req.divisor : div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? DATA_W'(shifted - {1'b0, dvs_ff}) : shifted[DATA_W-1:0];
         quo_in  = {quo_ff[DATA_W-2:0], fits};
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff  <= neg_in;
      iter_ff <= iter_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

/* design/sme_queue.sv */
module sme_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             enq,
   input  sme_pkg::cmd_type enq_data,
   output logic             full,
   input  logic             deq,
   output sme_pkg::cmd_type deq_data,
   output logic             empty
);
   import sme_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_enq;
   logic              do_deq;

   assign full     = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_enq   = enq && !full;
   assign do_deq   = deq && !empty;
   assign deq_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_enq && !do_deq) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_deq && !do_enq) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_enq) begin
         entry_ff[wr_ptr_ff] <= enq_data;
      end
   end

endmodule

/* design/sme_front.sv */
module sme_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  sme_pkg::req_type req_data,
   output logic             req_full,
   output logic             enq,
   output sme_pkg::cmd_type enq_data,
   input  logic             queue_full
);
   import sme_pkg::*;

   logic     stopped_ff, stopped_in;
   kind_type kind;

   // Once halted, or after a syntax error, every later instruction only reports the halted status.
   always_comb begin
      if (stopped_ff) begin
         kind = KIND_STOPPED;
      end else begin
         unique case (req_data.action)
            ACT_PUSH:           kind = KIND_PUSH;
            ACT_POP:            kind = KIND_POP;
            ACT_ADD:            kind = KIND_ADD;
            ACT_SUB:            kind = KIND_SUB;
            ACT_MUL:            kind = KIND_MUL;
            ACT_DIV:            kind = KIND_DIV;
            ACT_NOP, ACT_NOP2:  kind = KIND_NOP;
            ACT_DUMP:           kind = KIND_DUMP;
            ACT_HALT:           kind = KIND_HALT;
            default:            kind = KIND_SYNTAX;
         endcase
      end
   end

   assign req_full         = queue_full;
   assign enq              = req_push && !queue_full;
   assign enq_data.kind    = kind;
   assign enq_data.operand = req_data.operand;

   always_comb begin
      stopped_in = stopped_ff;
      if (enq && (kind == KIND_HALT || kind == KIND_SYNTAX)) begin
         stopped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
      end else begin
         stopped_ff <= stopped_in;
      end
   end

endmodule

/* design/sme_back.sv */
module sme_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_empty,
   input  sme_pkg::cmd_type     cmd_head,
   output logic                 cmd_pop,
   output logic                 ram_wr_en,
   output logic [sme_pkg::ADDR_W-1:0] ram_wr_addr,
   output logic [sme_pkg::DATA_W-1:0] ram_wr_data,
   output logic [sme_pkg::ADDR_W-1:0] ram_rd_addr,
   input  logic [sme_pkg::DATA_W-1:0] ram_rd_data,
   output sme_pkg::div_req_type div_req,
   input  sme_pkg::div_rsp_type div_rsp,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output sme_pkg::rsp_type     rsp_data
);
   import sme_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_DIV  = 4'b0100,
      S_DUMP = 4'b1000
   } state_type;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   // The top of the stack lives in top_ff; the RAM holds the entries below it.
   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   kind_type          rd_kind;
   logic              out_free;
   logic              emit;
   status_type        emit_status;
   logic [DATA_W-1:0] emit_value;
   logic              emit_element;
   logic              emit_last;
   logic              is_top;
   logic [DATA_W-1:0] top_or_zero;
   logic [DATA_W-1:0] arith;

   assign out_free    = !out_valid_ff || rsp_pop;
   assign top_or_zero = (cnt_ff == '0) ? '0 : top_ff;
   assign is_top      = CNT_W'(idx_ff) == cnt_ff - CNT_W'(1);
   assign rd_kind     = (state_ff == S_IDLE) ? cmd_head.kind : cmd_ff.kind;

   always_comb begin
      unique case (cmd_ff.kind)
         KIND_ADD: arith = ram_rd_data + top_ff;
         KIND_SUB: arith = ram_rd_data - top_ff;
         default:  arith = ram_rd_data * top_ff;
      endcase
   end

   always_comb begin
      if (state_ff == S_DUMP) begin
         ram_rd_addr = (out_free && !is_top) ? idx_ff + ADDR_W'(1) : idx_ff;
      end else if (rd_kind == KIND_DUMP) begin
         ram_rd_addr = '0;
      end else begin
         ram_rd_addr = ADDR_W'(cnt_ff - CNT_W'(2));
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      top_in       = top_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ADDR_W'(cnt_ff - CNT_W'(1));
      ram_wr_data  = top_ff;
      div_req      = '{start: 1'b0, dividend: ram_rd_data, divisor: top_ff};
      emit         = 1'b0;
      emit_status  = ST_OK;
      emit_value   = top_or_zero;
      emit_element = 1'b0;
      emit_last    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               emit     = 1'b1;
               unique case (cmd_ff.kind)
                  KIND_PUSH: begin
                     if (cnt_ff >= CNT_FULL) begin
                        emit_status = ST_OVER;
                     end else begin
                        ram_wr_en  = cnt_ff != '0;
                        top_in     = cmd_ff.operand;
                        cnt_in     = cnt_ff + CNT_W'(1);
                        emit_value = cmd_ff.operand;
                     end
                  end
                  KIND_POP: begin
                     if (cnt_ff == '0) begin
                        emit_status = ST_UNDER;
                     end else begin
                        top_in     = ram_rd_data;
                        cnt_in     = cnt_ff - CNT_W'(1);
                        emit_value = (cnt_ff == CNT_W'(1)) ? '0 : ram_rd_data;
                     end
                  end
                  KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                     if (cnt_ff < CNT_W'(2)) begin
                        emit_status = ST_UNDER;
                     end else if (cmd_ff.kind == KIND_DIV) begin
                        if (top_ff == '0) begin
                           emit_status = ST_DIVZERO;
                        end else begin
                           emit          = 1'b0;
                           div_req.start = 1'b1;
                           state_in      = S_DIV;
                        end
                     end else begin
                        top_in     = arith;
                        cnt_in     = cnt_ff - CNT_W'(1);
                        emit_value = arith;
                     end
                  end
                  KIND_DUMP: begin
                     if (cnt_ff == '0) begin
                        emit_value = '0;
                     end else begin
                        emit     = 1'b0;
                        idx_in   = '0;
                        state_in = S_DUMP;
                     end
                  end
                  KIND_HALT, KIND_STOPPED: emit_status = ST_HALTED;
                  KIND_SYNTAX:             emit_status = ST_SYNTAX;
                  default:                 emit_status = ST_OK;
               endcase
            end
         end
         S_DIV: begin
            if (!div_rsp.busy && out_free) begin
               emit       = 1'b1;
               top_in     = div_rsp.quotient;
               cnt_in     = cnt_ff - CNT_W'(1);
               emit_value = div_rsp.quotient;
               state_in   = S_IDLE;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               emit         = 1'b1;
               emit_element = 1'b1;
               emit_last    = is_top;
               emit_value   = is_top ? top_ff : ram_rd_data;
               if (is_top) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         out_valid_in      = 1'b1;
         out_in.status     = emit_status;
         out_in.value      = emit_value;
         out_in.is_element = emit_element;
         out_in.last       = emit_last;
         out_in.depth      = DEPTH_W'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff <= cmd_in;
      top_ff <= top_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* design/stack_machine_executor_top.sv */
// Channel   Direction  Handshake             Payload
// req_      in         req_push / req_full   req_data (action, operand)
// rsp_      out        rsp_pop / rsp_empty   rsp_data (status, value, is_element, last, depth)
// A plain instruction passes through the execution unit: the idle state takes it from the
// two-entry command queue and reads the stack RAM, and the execute state computes and
// registers the result. The radix-2 divider retires one quotient bit a cycle.
// A dump emits the elements bottom first, reading each but the top one from the stack RAM.
// Reset is synchronous and needs no clearing pass; the first instruction is taken at once.
// req_full is high while the command queue holds two; an unread result stalls execution.
module stack_machine_executor_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  sme_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sme_pkg::rsp_type rsp_data
);
   import sme_pkg::*;

   logic              enq;
   cmd_type           enq_data;
   logic              queue_full;
   logic              cmd_pop;
   cmd_type           cmd_head;
   logic              cmd_empty;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   sme_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .enq        (enq),
      .enq_data   (enq_data),
      .queue_full (queue_full)
   );

   sme_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (enq),
      .enq_data (enq_data),
      .full     (queue_full),
      .deq      (cmd_pop),
      .deq_data (cmd_head),
      .empty    (cmd_empty)
   );

   sme_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   sme_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sme_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

/* design/sme_checker.sv */
`include "stack_machine_executor_top_macros.svh"

module sme_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input sme_pkg::rsp_type rsp_data
);
   import sme_pkg::*;

   logic waiting;
   logic held;
   logic element;
   logic elem_ok;
   logic mid_dump;
   logic depth_ok;
   logic idle_in;

   assign waiting  = !rsp_empty;
   assign held     = waiting && !rsp_pop;
   assign element  = waiting && rsp_data.is_element;
   assign elem_ok  = rsp_data.status == ST_OK && rsp_data.depth != '0;
   assign mid_dump = waiting && !rsp_data.last;
   assign depth_ok = rsp_data.depth <= DEPTH_W'(STACK_DEPTH);
   assign idle_in  = !req_full && !req_push;

   `SME_ASSERT_NEXT(a_rsp_held, held, waiting && $stable(rsp_data), "waiting result changed")
   `SME_ASSERT_NOW(a_element_ok, element, elem_ok, "bad dumped element")
   `SME_ASSERT_NOW(a_only_dump_multi, mid_dump, rsp_data.is_element, "stray non-final result")
   `SME_ASSERT_NOW(a_depth_bound, waiting, depth_ok, "stack depth out of range")
   `SME_ASSERT_NEXT(a_full_needs_push, idle_in, !req_full, "queue filled without a transfer")

endmodule

bind stack_machine_executor_top sme_checker u_checker (.*);
